// ===== rtl/rsfa_pkg.sv =====
// Shared types and constants of the record slot free-list allocator.
// No dependencies; compiled first.
package rsfa_pkg;

	localparam int SLOT_W = 11;  // slot fields on the channels
	localparam int OFS_W  = 26;  // byte offset field
	localparam int REC_W  = 16;  // record_bytes register
	localparam int HDR_W  = 8;   // header_bytes register
	localparam int CFG_W  = 16;  // config write data, widest register
	localparam int CFG_IW = 1;   // config register index

	typedef logic [1:0]        req_type_t;
	typedef logic [1:0]        status_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [OFS_W-1:0]  ofs_t;
	typedef logic [REC_W-1:0]  rec_t;
	typedef logic [HDR_W-1:0]  hdr_t;
	typedef logic [CFG_W-1:0]  cfg_data_t;
	typedef logic [CFG_IW-1:0] cfg_idx_t;

	// request codes
	localparam req_type_t REQ_ALLOC = 2'd0;
	localparam req_type_t REQ_FREE  = 2'd1;
	localparam req_type_t REQ_READ  = 2'd2;
	localparam req_type_t REQ_WRITE = 2'd3;

	// result status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// configuration register indexes
	localparam cfg_idx_t CFG_RECORD_BYTES = 1'd0;
	localparam cfg_idx_t CFG_HEADER_BYTES = 1'd1;

	// control bundle from the exec stage to the offset stage
	typedef struct packed {
		logic    load;  // offset register takes a new transaction
		logic    ok;    // status is ST_OK, offset is meaningful
	} ofs_ctl_t;

endpackage

// ===== rtl/rsfa_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on rsfa_pkg.
interface rsfa_req_if;
	logic                 valid;
	logic                 ready;
	rsfa_pkg::req_type_t  req_type;
	rsfa_pkg::slot_t      slot_in;

	modport source (output valid, output req_type, output slot_in, input ready);
	modport sink   (input valid, input req_type, input slot_in, output ready);
endinterface

interface rsfa_rsp_if;
	logic               valid;
	logic               ready;
	rsfa_pkg::status_t  status;
	rsfa_pkg::slot_t    slot_out;
	rsfa_pkg::ofs_t     byte_offset;
	rsfa_pkg::slot_t    live_count;

	modport source (output valid, output status, output slot_out, output byte_offset,
		output live_count, input ready);
	modport sink   (input valid, input status, input slot_out, input byte_offset,
		input live_count, output ready);
endinterface

// ===== rtl/rsfa_link_mem.sv =====
// Link memory of the free list: one write port, one read port, registered read.
// No package dependencies.
module rsfa_link_mem #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 11,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/rsfa_offset.sv =====
// Offset stage: header_bytes + index * record_bytes, masked to the offset width.
// Depends on rsfa_pkg.
module rsfa_offset #(
	parameter int IDX_W = 11
) (
	input  logic              clk,
	input  rsfa_pkg::ofs_ctl_t ctl,
	input  logic [IDX_W-1:0]  idx,
	input  rsfa_pkg::rec_t    record_bytes,
	input  rsfa_pkg::hdr_t    header_bytes,
	output rsfa_pkg::ofs_t    offset_q
);

	localparam int PROD_W = IDX_W + rsfa_pkg::REC_W;

	logic [PROD_W-1:0] prod;
	logic [PROD_W:0]   sum;

	always_comb begin
		prod = idx * record_bytes;
		sum  = {1'b0, prod} + (PROD_W + 1)'(header_bytes);
	end

	// errors report offset zero
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			offset_q <= ctl.ok ? sum[rsfa_pkg::OFS_W-1:0] : '0;
		end
	end

endmodule

// ===== rtl/record_slot_free_list_allocator_unit.sv =====
// Record slot free-list allocator, top level.
// Depends on rsfa_pkg, rsfa_if, rsfa_link_mem and rsfa_offset.
//
// Use:
//  - req (sink): req_type and slot_in. A transaction is taken when valid and
//    ready are high at a clock edge. Allocate pops the free-list head, or the
//    next fresh slot when the list is empty; free pushes a slot; read and
//    write only range-check the slot against the high-water mark.
//  - rsp (source): one result per request, in order: status, slot_out,
//    byte_offset and live_count.
//  - cfg_we / cfg_idx / cfg_data: register writes (0 record_bytes,
//    1 header_bytes), only while no request is in flight.
// Path: a request passes the exec stage, the offset stage input and the output register before rsp.valid rises.
// Flow: a new request is not taken while one is in exec. The link memory is read
// at accept and the head pointer is updated when the request leaves the exec
// stage, so the next request waits for that update before it is taken.
// Reset: empty free list, high-water mark 1, live count 0, registers at
// record_bytes 1 and header_bytes 16. The link memory is not cleared; no
// entry read from it is used before a free writes it.
// Stall: when rsp is stalled the result holds in the output register, one
// more request can finish exec behind it and one more is taken into exec,
// which then holds req.ready low.
module record_slot_free_list_allocator_unit #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	rsfa_req_if.sink             req,
	rsfa_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  rsfa_pkg::cfg_idx_t   cfg_idx,
	input  rsfa_pkg::cfg_data_t  cfg_data
);

	// state must hold one past the last slot (exhausted high-water mark)
	localparam int CW     = $clog2(SLOT_COUNT + 2);
	localparam int ST_W   = (CW > rsfa_pkg::SLOT_W) ? CW : rsfa_pkg::SLOT_W;
	localparam int ADDR_W = $clog2(SLOT_COUNT);
	localparam logic [ST_W-1:0] SLOT_MAX = ST_W'(SLOT_COUNT);
	localparam logic [ST_W-1:0] ONE      = ST_W'(1);

	// configuration registers
	rsfa_pkg::rec_t record_bytes_q;
	rsfa_pkg::hdr_t header_bytes_q;

	// allocator state
	logic [ST_W-1:0] fresh_mark_q;
	logic [ST_W-1:0] free_head_q;
	logic [ST_W-1:0] used_total_q;

	// exec stage
	logic                s1_v;
	rsfa_pkg::req_type_t req_s1;
	logic [ST_W-1:0]     slot_s1;

	// offset stage input
	logic                s2_v;
	rsfa_pkg::status_t   status_s2;
	logic [ST_W-1:0]     slot_s2;
	logic [ST_W-1:0]     live_s2;

	// output register
	logic                s3_v;
	rsfa_pkg::status_t   status_s3;
	rsfa_pkg::slot_t     slot_s3;
	rsfa_pkg::slot_t     live_s3;
	rsfa_pkg::ofs_t      offset_s3;

	logic accept;
	logic s3_load;
	logic s2_load;

	// link memory
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ST_W-1:0]   mem_wdata;
	logic [ST_W-1:0]   mem_rdata;
	logic [ST_W-1:0]   head_m1;

	// exec results
	rsfa_pkg::status_t ex_status;
	logic [ST_W-1:0]   ex_slot;
	logic [ST_W-1:0]   ex_slot_m1;
	logic [ST_W-1:0]   nxt_head;
	logic [ST_W-1:0]   nxt_fresh;
	logic [ST_W-1:0]   nxt_used;

	rsfa_pkg::ofs_ctl_t ofs_ctl;
	logic [ST_W-1:0]    ofs_idx;

	// handshake: one request in exec at a time
	assign s3_load  = s2_v && (!s3_v || rsp.ready);
	assign s2_load  = s1_v && (!s2_v || s3_load);
	assign req.ready = !s1_v;
	assign accept   = req.valid && req.ready;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_bytes_q <= rsfa_pkg::REC_W'(1);
			header_bytes_q <= rsfa_pkg::HDR_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rsfa_pkg::CFG_RECORD_BYTES: record_bytes_q <= cfg_data;
				rsfa_pkg::CFG_HEADER_BYTES: header_bytes_q <= cfg_data[rsfa_pkg::HDR_W-1:0];
				default: ;
			endcase
		end
	end

	// read the link of the current head when a request is taken; the head
	// cannot change until that request leaves exec
	assign head_m1 = free_head_q - ONE;

	rsfa_link_mem #(
		.DEPTH  (SLOT_COUNT),
		.WIDTH  (ST_W),
		.ADDR_W (ADDR_W)
	) u_link_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (head_m1[ADDR_W-1:0]),
		.rdata (mem_rdata)
	);

	// exec: decide the slot, update head, mark and count
	always_comb begin
		ex_status = rsfa_pkg::ST_OK;
		ex_slot   = '0;
		nxt_head  = free_head_q;
		nxt_fresh = fresh_mark_q;
		nxt_used  = used_total_q;
		mem_we    = 1'b0;
		mem_wdata = free_head_q;
		if (req_s1 == rsfa_pkg::REQ_ALLOC) begin
			priority if (free_head_q != '0 && free_head_q <= SLOT_MAX) begin
				ex_slot  = free_head_q;
				nxt_head = mem_rdata;
			end else if (fresh_mark_q <= SLOT_MAX) begin
				ex_slot   = fresh_mark_q;
				nxt_fresh = fresh_mark_q + ONE;
			end else begin
				ex_status = rsfa_pkg::ST_FULL;
			end
			if (ex_status == rsfa_pkg::ST_OK && used_total_q < SLOT_MAX) begin
				nxt_used = used_total_q + ONE;
			end
		end else if (slot_s1 == '0 || slot_s1 >= fresh_mark_q) begin
			ex_status = rsfa_pkg::ST_RANGE;
		end else begin
			ex_slot = slot_s1;
			if (req_s1 == rsfa_pkg::REQ_FREE) begin
				mem_we   = s2_load;
				nxt_head = slot_s1;
				if (used_total_q != '0) begin
					nxt_used = used_total_q - ONE;
				end
			end
		end
		ex_slot_m1 = ex_slot - ONE;
	end

	assign mem_waddr = ex_slot_m1[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_mark_q <= ONE;
			free_head_q  <= '0;
			used_total_q <= '0;
			s1_v         <= 1'b0;
			s2_v         <= 1'b0;
			s3_v         <= 1'b0;
		end else begin
			if (s2_load) begin
				fresh_mark_q <= nxt_fresh;
				free_head_q  <= nxt_head;
				used_total_q <= nxt_used;
			end
			if (accept) begin
				s1_v <= 1'b1;
			end else if (s2_load) begin
				s1_v <= 1'b0;
			end
			if (s2_load) begin
				s2_v <= 1'b1;
			end else if (s3_load) begin
				s2_v <= 1'b0;
			end
			if (s3_load) begin
				s3_v <= 1'b1;
			end else if (rsp.ready) begin
				s3_v <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req.req_type;
			slot_s1 <= ST_W'(req.slot_in);
		end
		if (s2_load) begin
			status_s2 <= ex_status;
			slot_s2   <= ex_slot;
			live_s2   <= nxt_used;
		end
		if (s3_load) begin
			status_s3 <= status_s2;
			slot_s3   <= slot_s2[rsfa_pkg::SLOT_W-1:0];
			live_s3   <= live_s2[rsfa_pkg::SLOT_W-1:0];
		end
	end

	// offset multiply-add in its own stage
	assign ofs_ctl.load = s3_load;
	assign ofs_ctl.ok   = (status_s2 == rsfa_pkg::ST_OK);
	assign ofs_idx      = slot_s2 - ONE;

	rsfa_offset #(
		.IDX_W (ST_W)
	) u_offset (
		.clk          (clk),
		.ctl          (ofs_ctl),
		.idx          (ofs_idx),
		.record_bytes (record_bytes_q),
		.header_bytes (header_bytes_q),
		.offset_q     (offset_s3)
	);

	assign rsp.valid       = s3_v;
	assign rsp.status      = status_s3;
	assign rsp.slot_out    = slot_s3;
	assign rsp.byte_offset = offset_s3;
	assign rsp.live_count  = live_s3;

	// live count never exceeds the slot count
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_total_q <= SLOT_MAX)
		else $error("live count above slot count");

	// a non-empty head always lies below the high-water mark
	a_head_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q < fresh_mark_q)
		else $error("free-list head at or above high-water mark");

	// high-water mark stays within one past the last slot
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_mark_q != '0 && fresh_mark_q <= SLOT_MAX + ONE)
		else $error("high-water mark out of range");

	// a link write never lands in the cycle the head link is read
	a_mem_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && accept))
		else $error("link memory read and write overlap");

	// allocator state changes only when a transaction leaves exec
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s2_load |=> $stable(free_head_q) && $stable(fresh_mark_q))
		else $error("allocator state changed outside exec");

endmodule
